/* design/nbce_pkg.sv */
// Package: shared widths, decode codes and types of the nine-bit execute step.
`timescale 1ns / 1ps
`default_nettype none

package nbce_pkg;

  localparam int INSN_W      = 9;
  localparam int PLEN_W      = 10;
  localparam int DATA_W      = 8;
  localparam int REG_CNT     = 4;
  localparam int REG_IDX_W   = 2;
  localparam int MEM_DEPTH   = 256;
  localparam int MEM_AW      = 8;
  localparam int PC_WIDTH_DEF = 10;

  // Sub-operation of the all-zero group, selected by bits 3:2.
  localparam logic [1:0] OP0_NOP = 2'd0;
  localparam logic [1:0] OP0_JF  = 2'd1;
  localparam logic [1:0] OP0_JMP = 2'd2;
  localparam logic [1:0] OP0_INC = 2'd3;

  typedef logic [REG_CNT-1:0][DATA_W-1:0] regfile_t;

  typedef struct packed {
    logic                 halted;
    logic                 flag;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    reg_value;
    logic                 mem_written;
    logic [MEM_AW-1:0]    mem_address;
    logic [DATA_W-1:0]    mem_value;
  } exec_t;

endpackage

`default_nettype wire

/* design/nbce_if.sv */
// Interfaces: instruction, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface nbce_in_if;
  logic                        valid;
  logic                        ready;
  logic [nbce_pkg::INSN_W-1:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface nbce_out_if #(
  parameter int PC_WIDTH = nbce_pkg::PC_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [PC_WIDTH-1:0]            next_pc;
  logic                           halted;
  logic                           flag_out;
  logic                           reg_written;
  logic [nbce_pkg::REG_IDX_W-1:0] written_reg_index;
  logic [nbce_pkg::DATA_W-1:0]    written_reg_value;
  logic                           mem_written;
  logic [nbce_pkg::MEM_AW-1:0]    mem_address;
  logic [nbce_pkg::DATA_W-1:0]    mem_value;
  modport source (output valid, output next_pc, output halted, output flag_out,
                  output reg_written, output written_reg_index,
                  output written_reg_value, output mem_written,
                  output mem_address, output mem_value, input ready);
  modport sink (input valid, input next_pc, input halted, input flag_out,
                input reg_written, input written_reg_index,
                input written_reg_value, input mem_written,
                input mem_address, input mem_value, output ready);
endinterface

interface nbce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [nbce_pkg::PLEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/nbce_dmem.sv */
// Data memory: 256 bytes, registered read, per-entry valid bits, store bypass.
`timescale 1ns / 1ps
`default_nettype none

module nbce_dmem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [nbce_pkg::MEM_AW-1:0]   wr_addr_i,
  input  wire logic [nbce_pkg::DATA_W-1:0]   wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [nbce_pkg::MEM_AW-1:0]   rd_addr_i,
  output logic      [nbce_pkg::DATA_W-1:0]   rd_data_o
);

  logic [nbce_pkg::DATA_W-1:0]    mem [nbce_pkg::MEM_DEPTH];
  logic [nbce_pkg::MEM_DEPTH-1:0] vld_q;
  logic [nbce_pkg::DATA_W-1:0]    rd_q;
  logic                           rd_vld_q;
  logic                           byp_q;
  logic [nbce_pkg::DATA_W-1:0]    byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        byp_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // store landing on the same edge wins; never-written bytes read as zero
  assign rd_data_o = byp_q    ? byp_data_q :
                     rd_vld_q ? rd_q       : '0;

endmodule

`default_nettype wire

/* design/nbce_alu.sv */
// Execute logic: decodes one instruction and computes its effects and next pc.
`timescale 1ns / 1ps
`default_nettype none

module nbce_alu #(
  parameter int PC_WIDTH = nbce_pkg::PC_WIDTH_DEF
) (
  input  wire logic [nbce_pkg::INSN_W-1:0] word_i,
  input  wire logic [PC_WIDTH-1:0]         pc_i,
  input  wire logic                        flag_i,
  input  wire nbce_pkg::regfile_t          regs_i,
  input  wire logic [nbce_pkg::PLEN_W-1:0] plen_i,
  input  wire logic [nbce_pkg::DATA_W-1:0] ld_data_i,
  output logic      [PC_WIDTH-1:0]         npc_o,
  output nbce_pkg::exec_t                  ex_o
);

  localparam int CmpW = (PC_WIDTH > nbce_pkg::PLEN_W) ? PC_WIDTH : nbce_pkg::PLEN_W;

  logic [nbce_pkg::INSN_W-1:0]    w;
  logic [nbce_pkg::REG_IDX_W-1:0] a;
  logic [nbce_pkg::REG_IDX_W-1:0] b;
  logic [nbce_pkg::REG_IDX_W-1:0] ri;
  logic [nbce_pkg::DATA_W-1:0]    x;
  logic [nbce_pkg::DATA_W-1:0]    y;
  logic [nbce_pkg::DATA_W-1:0]    r;
  logic [PC_WIDTH-1:0]            npc;

  always_comb begin
    // halted core executes a no-op
    w  = (CmpW'(pc_i) >= CmpW'(plen_i)) ? '0 : word_i;
    a  = w[3:2];
    b  = w[1:0];
    x  = regs_i[a];
    y  = regs_i[b];
    ri = w[5:4];
    r  = regs_i[ri];
    npc = pc_i + PC_WIDTH'(1);
    ex_o = '0;
    ex_o.flag = flag_i;

    if (w[8]) begin
      if (w[7] && w[6]) begin
        npc = w[5] ? (pc_i - PC_WIDTH'(w[4:0])) : (pc_i + PC_WIDTH'(w[4:0]));
      end else begin
        ex_o.reg_written = 1'b1;
        ex_o.reg_index   = ri;
        if (w[7]) begin
          ex_o.reg_value = r & {4'h0, w[3:0]};
        end else if (w[6]) begin
          ex_o.reg_value = r | {w[3:0], 4'h0};
        end else begin
          ex_o.reg_value = r | {4'h0, w[3:0]};
        end
      end
    end else if (w[7] && w[6]) begin
      ex_o.reg_written = 1'b1;
      ex_o.reg_index   = w[4:3];
      ex_o.reg_value   = w[5] ? (regs_i[w[4:3]] >> w[2:0]) : (regs_i[w[4:3]] << w[2:0]);
    end else if (w[7]) begin
      if (w[5]) begin
        if (w[4]) begin
          ex_o.mem_written = 1'b1;
          ex_o.mem_address = y;
          ex_o.mem_value   = x;
        end else begin
          ex_o.reg_written = 1'b1;
          ex_o.reg_index   = a;
          ex_o.reg_value   = ld_data_i;
        end
      end else begin
        // shifts of 8 or more clear the byte
        ex_o.reg_written = 1'b1;
        ex_o.reg_index   = a;
        ex_o.reg_value   = w[4] ? (x >> y) : (x << y);
      end
    end else if (w[6] && w[5]) begin
      if (w[4]) begin
        ex_o.reg_written = 1'b1;
        ex_o.reg_index   = a;
        ex_o.reg_value   = y;
      end else begin
        ex_o.flag = (x == y);
      end
    end else if (w[6]) begin
      ex_o.reg_written = 1'b1;
      ex_o.reg_index   = a;
      ex_o.reg_value   = w[4] ? (x + y) : (x - y);
    end else if (w[5]) begin
      ex_o.reg_written = 1'b1;
      ex_o.reg_index   = a;
      ex_o.reg_value   = w[4] ? (x & y) : (x | y);
    end else if (w[4]) begin
      ex_o.reg_written = 1'b1;
      ex_o.reg_index   = a;
      ex_o.reg_value   = x ^ y;
    end else begin
      unique case (a)
        nbce_pkg::OP0_INC: begin
          ex_o.reg_written = 1'b1;
          ex_o.reg_index   = b;
          ex_o.reg_value   = y + 8'd1;
        end
        nbce_pkg::OP0_JMP: begin
          npc = PC_WIDTH'(y);
        end
        nbce_pkg::OP0_JF: begin
          if (flag_i) begin
            npc = PC_WIDTH'(y);
          end
        end
        nbce_pkg::OP0_NOP: begin
        end
        default: begin
        end
      endcase
    end

    ex_o.halted = CmpW'(npc) >= CmpW'(plen_i);
    npc_o = npc;
  end

endmodule

`default_nettype wire

/* design/nine_bit_cpu_execute_step.sv */
// Top level: nine-bit core execute step with input, execute and result stages.
//
//  channel | dir | payload                            | beat
//  in_i    | in  | instruction_word                   | valid & ready
//  cfg_i   | in  | data = program_length              | valid & ready
//  out_o   | out | next_pc, halted, flag, reg/mem wr  | valid & ready
//
// One instruction per cycle sustained while the result side keeps up; from the input
// beat to the result beat: data memory read at accept, execute, result register.
// The load address at accept comes from the register file with the executing
// beat's write forwarded.
// Reset clears pc, flag, registers and the memory valid bits at once; no sweep.
// A stalled result holds the execute stage, which then holds the input.
`timescale 1ns / 1ps
`default_nettype none

module nine_bit_cpu_execute_step #(
  parameter int PC_WIDTH = nbce_pkg::PC_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nbce_in_if.sink   in_i,
  nbce_cfg_if.sink  cfg_i,
  nbce_out_if.source out_o
);

  logic [nbce_pkg::PLEN_W-1:0] plen_q;
  logic [PC_WIDTH-1:0]         pc_q;
  logic                        flag_q;
  nbce_pkg::regfile_t          regs_q;
  nbce_pkg::regfile_t          regs_d;

  logic                        e_valid_q;
  logic [nbce_pkg::INSN_W-1:0] e_word_q;
  logic                        e_fire;
  logic                        in_fire;

  logic [nbce_pkg::DATA_W-1:0] ld_data;
  logic [PC_WIDTH-1:0]         e_npc;
  nbce_pkg::exec_t             ex;

  logic                        out_valid_q;
  logic [PC_WIDTH-1:0]         out_pc_q;
  nbce_pkg::exec_t             out_ex_q;

  assign cfg_i.ready = 1'b1;
  assign e_fire      = e_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !e_valid_q || e_fire;
  assign in_fire     = in_i.valid && in_i.ready;

  // register file as it stands after the executing beat retires
  always_comb begin
    regs_d = regs_q;
    if (e_fire && ex.reg_written) begin
      regs_d[ex.reg_index] = ex.reg_value;
    end
  end

  nbce_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (e_fire && ex.mem_written),
    .wr_addr_i (ex.mem_address),
    .wr_data_i (ex.mem_value),
    .rd_en_i   (in_fire),
    .rd_addr_i (regs_d[in_i.instruction_word[1:0]]),
    .rd_data_o (ld_data)
  );

  nbce_alu #(
    .PC_WIDTH (PC_WIDTH)
  ) u_alu (
    .word_i    (e_word_q),
    .pc_i      (pc_q),
    .flag_i    (flag_q),
    .regs_i    (regs_q),
    .plen_i    (plen_q),
    .ld_data_i (ld_data),
    .npc_o     (e_npc),
    .ex_o      (ex)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      pc_q        <= '0;
      flag_q      <= 1'b0;
      regs_q      <= '0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        plen_q <= cfg_i.data;
      end
      if (in_fire) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        pc_q        <= e_npc;
        flag_q      <= ex.flag;
        regs_q      <= regs_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_word_q <= in_i.instruction_word;
    end
    if (e_fire) begin
      out_pc_q <= e_npc;
      out_ex_q <= ex;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.next_pc           = out_pc_q;
  assign out_o.halted            = out_ex_q.halted;
  assign out_o.flag_out          = out_ex_q.flag;
  assign out_o.reg_written       = out_ex_q.reg_written;
  assign out_o.written_reg_index = out_ex_q.reg_index;
  assign out_o.written_reg_value = out_ex_q.reg_value;
  assign out_o.mem_written       = out_ex_q.mem_written;
  assign out_o.mem_address       = out_ex_q.mem_address;
  assign out_o.mem_value         = out_ex_q.mem_value;

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !e_valid_q |-> in_i.ready)
    else $error("input not ready with execute stage empty");

  a_retire_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire |=> (out_valid_q && pc_q == out_pc_q))
    else $error("retired beat not in result register");

  a_one_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ex_q.mem_written) |-> !out_ex_q.reg_written)
    else $error("store also reports a register write");

  a_no_reg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ex_q.reg_written) |->
      (out_ex_q.reg_index == '0 && out_ex_q.reg_value == '0))
    else $error("register fields not cleared without a write");

endmodule

`default_nettype wire

/* verif/nbce_tb_pkg.sv */
// Testbench package: instruction field codes, result record and the shadow core scoreboard.
`timescale 1ns / 1ps

package nbce_tb_pkg;
  import nbce_pkg::*;

  localparam int PC_W = PC_WIDTH_DEF;

  // bit 8 set: bits 7:6 select the immediate op
  localparam logic [1:0] IMM_ORL = 2'd0;
  localparam logic [1:0] IMM_ORH = 2'd1;
  localparam logic [1:0] IMM_AND = 2'd2;
  localparam logic [1:0] IMM_BR  = 2'd3;

  localparam logic [2:0] PFX_SHI = 3'b011;
  localparam logic [3:0] PFX_MEM = 4'b0101;
  localparam logic [3:0] PFX_RSH = 4'b0100;

  // bits 8:4 of the register-register group
  localparam logic [4:0] OP_MISC = 5'b00000;
  localparam logic [4:0] OP_XOR  = 5'b00001;
  localparam logic [4:0] OP_OR   = 5'b00010;
  localparam logic [4:0] OP_AND  = 5'b00011;
  localparam logic [4:0] OP_SUB  = 5'b00100;
  localparam logic [4:0] OP_ADD  = 5'b00101;
  localparam logic [4:0] OP_CMP  = 5'b00110;
  localparam logic [4:0] OP_MOV  = 5'b00111;

  typedef struct packed {
    logic [PC_W-1:0]      next_pc;
    logic                 halted;
    logic                 flag;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    reg_value;
    logic                 mem_written;
    logic [MEM_AW-1:0]    mem_address;
    logic [DATA_W-1:0]    mem_value;
  } step_result_t;

  function automatic string show(step_result_t s);
    return $sformatf("pc=%0d halt=%0b flag=%0b rw=%0b r%0d=%02h mw=%0b [%02h]=%02h",
                     s.next_pc, s.halted, s.flag, s.reg_written, s.reg_index,
                     s.reg_value, s.mem_written, s.mem_address, s.mem_value);
  endfunction

  class core_shadow;
    logic [PLEN_W-1:0] plen;
    logic [PC_W-1:0]   pc;
    logic              flag;
    logic [DATA_W-1:0] regs [REG_CNT];
    logic [DATA_W-1:0] dmem [MEM_DEPTH];
    step_result_t      steps [$];
    int                errors;

    function new();
      plen   = '0;
      pc     = '0;
      flag   = 1'b0;
      errors = 0;
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
    endfunction

    function void set_length(logic [PLEN_W-1:0] len);
      plen = len;
    endfunction

    function int pending();
      return steps.size();
    endfunction

    // Executes one accepted instruction; returns 0 when the core was halted.
    function bit execute(logic [INSN_W-1:0] word);
      logic [INSN_W-1:0] w;
      logic [PC_W-1:0]   npc;
      logic [1:0]        a;
      logic [1:0]        b;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      step_result_t      r;
      bit                live;
      live = (pc < plen);
      w    = live ? word : '0;
      a    = w[3:2];
      b    = w[1:0];
      x    = regs[a];
      y    = regs[b];
      npc  = pc + 1'b1;
      r    = '0;
      if (w[8]) begin
        r.reg_index = w[5:4];
        if (w[7:6] == IMM_BR) begin
          npc = w[5] ? pc - w[4:0] : pc + w[4:0];
        end else begin
          r.reg_written = 1'b1;
          case (w[7:6])
            IMM_AND: r.reg_value = regs[w[5:4]] & {4'h0, w[3:0]};
            IMM_ORH: r.reg_value = regs[w[5:4]] | {w[3:0], 4'h0};
            default: r.reg_value = regs[w[5:4]] | {4'h0, w[3:0]};
          endcase
        end
      end else if (w[8:6] == PFX_SHI) begin
        r.reg_written = 1'b1;
        r.reg_index   = w[4:3];
        r.reg_value   = w[5] ? regs[w[4:3]] >> w[2:0] : regs[w[4:3]] << w[2:0];
      end else if (w[8:5] == PFX_MEM) begin
        if (w[4]) begin
          r.mem_written = 1'b1;
          r.mem_address = y;
          r.mem_value   = x;
        end else begin
          r.reg_written = 1'b1;
          r.reg_index   = a;
          r.reg_value   = dmem[y];
        end
      end else if (w[8:5] == PFX_RSH) begin
        r.reg_written = 1'b1;
        r.reg_index   = a;
        if (y >= 8) r.reg_value = '0;
        else r.reg_value = w[4] ? x >> y : x << y;
      end else begin
        r.reg_written = 1'b1;
        r.reg_index   = a;
        case (w[8:4])
          OP_MOV: r.reg_value = y;
          OP_CMP: begin
            flag          = (x == y);
            r.reg_written = 1'b0;
          end
          OP_ADD: r.reg_value = x + y;
          OP_SUB: r.reg_value = x - y;
          OP_AND: r.reg_value = x & y;
          OP_OR:  r.reg_value = x | y;
          OP_XOR: r.reg_value = x ^ y;
          default: begin
            r.reg_written = 1'b0;
            case (a)
              OP0_INC: begin
                r.reg_written = 1'b1;
                r.reg_index   = b;
                r.reg_value   = y + 1'b1;
              end
              OP0_JMP: npc = PC_W'(y);
              OP0_JF:  if (flag) npc = PC_W'(y);
              default: ;
            endcase
          end
        endcase
      end
      if (r.reg_written) begin
        regs[r.reg_index] = r.reg_value;
      end else begin
        r.reg_index = '0;
        r.reg_value = '0;
      end
      if (r.mem_written) dmem[r.mem_address] = r.mem_value;
      pc       = npc;
      r.next_pc = npc;
      r.halted  = (npc >= plen);
      r.flag    = flag;
      steps.push_back(r);
      return live;
    endfunction

    function void check_step(step_result_t got);
      step_result_t want;
      if (steps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %s", show(got));
        return;
      end
      want = steps.pop_front();
      if (want.next_pc !== got.next_pc || want.halted !== got.halted ||
          want.flag !== got.flag || want.reg_written !== got.reg_written ||
          want.reg_index !== got.reg_index || want.reg_value !== got.reg_value ||
          want.mem_written !== got.mem_written ||
          want.mem_address !== got.mem_address || want.mem_value !== got.mem_value) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction

    function void close();
      errors += steps.size();
    endfunction
  endclass

endpackage

/* verif/tb.sv */
// Testbench top: drives the nine-bit execute step and scores every result beat.
`timescale 1ns / 1ps

module tb;
  import nbce_pkg::*;
  import nbce_tb_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  nbce_in_if                    in_if ();
  nbce_cfg_if                   cfg_if ();
  nbce_out_if #(.PC_WIDTH(PC_W)) out_if ();

  nine_bit_cpu_execute_step #(.PC_WIDTH(PC_W)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  core_shadow shadow = new();
  bit         idle_on = 1'b1;
  int         hold_asks = 0;
  int         quiet_cycles = 0;

  function automatic logic [INSN_W-1:0] random_insn();
    logic [INSN_W-1:0] w;
    w = INSN_W'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        w[8]   = 1'b1;
        w[7:6] = 2'($urandom_range(0, 2));
      end
      1: w[8:4] = OP_MISC;
      2: w[8:5] = PFX_MEM;
      3: w[8:4] = OP_CMP;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_insn(input logic [INSN_W-1:0] w, output bit live);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.instruction_word <= w;
    do @(posedge clk_i); while (!in_if.ready);
    live = shadow.execute(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_plen(input logic [PLEN_W-1:0] len);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow.set_length(len);
  endtask

  task automatic run_random(input int live_goal, input int item_cap);
    int live_cnt;
    int sent;
    bit live;
    live_cnt = 0;
    sent     = 0;
    while (live_cnt < live_goal && sent < item_cap) begin
      send_insn(random_insn(), live);
      live_cnt += live;
      sent++;
    end
  endtask

  // result side: score beats, random stalls, long hold-off on request
  initial begin
    step_result_t got;
    int           stall_left;
    int           hold_left;
    int           holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.next_pc     = out_if.next_pc;
        got.halted      = out_if.halted;
        got.flag        = out_if.flag_out;
        got.reg_written = out_if.reg_written;
        got.reg_index   = out_if.written_reg_index;
        got.reg_value   = out_if.written_reg_value;
        got.mem_written = out_if.mem_written;
        got.mem_address = out_if.mem_address;
        got.mem_value   = out_if.mem_value;
        shadow.check_step(got);
      end
      if (holds_done != hold_asks) begin
        holds_done++;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [INSN_W-1:0] directed [$];
    bit                live;
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.instruction_word <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed = '{
      {1'b1, IMM_ORL, 2'd0, 4'hF},
      {1'b1, IMM_BR, 1'b1, 5'd31},   // minus branch wraps below zero
      {1'b1, IMM_BR, 1'b0, 5'd31},   // plus branch wraps back
      {1'b1, IMM_ORH, 2'd1, 4'hF},
      {1'b1, IMM_ORL, 2'd2, 4'h5},
      {1'b1, IMM_ORH, 2'd2, 4'hA},
      {1'b1, IMM_AND, 2'd2, 4'hC},
      {OP_ADD, 2'd0, 2'd2},
      {OP_SUB, 2'd3, 2'd1},
      {OP_OR, 2'd3, 2'd0},
      {OP_AND, 2'd0, 2'd1},
      {OP_XOR, 2'd1, 2'd3},
      {OP_MOV, 2'd2, 2'd0},
      {OP_CMP, 2'd2, 2'd0},
      {PFX_SHI, 1'b0, 2'd3, 3'd7},
      {PFX_SHI, 1'b1, 2'd1, 3'd7},
      {PFX_MEM, 1'b1, 2'd0, 2'd1},
      {PFX_MEM, 1'b0, 2'd2, 2'd1},
      {PFX_RSH, 1'b0, 2'd1, 2'd3},
      {PFX_RSH, 1'b1, 2'd0, 2'd0},
      {OP_MISC, OP0_INC, 2'd3},
      {OP_MISC, OP0_JF, 2'd0},
      {OP_MISC, OP0_JMP, 2'd2},
      {OP_MISC, OP0_NOP, 2'd1},
      9'h1FF
    };

    write_plen(10'd1023);
    foreach (directed[i]) send_insn(directed[i], live);

    // halted core: every word is taken as a no-op
    write_plen(10'd0);
    run_random(1000, 12);

    write_plen(10'd1023);
    run_random(175, 600);
    drain();
    run_random(175, 600);

    idle_on = 1'b0;
    hold_asks++;
    run_random(100, 300);
    idle_on = 1'b1;

    write_plen(10'd1);
    run_random(1000, 40);

    write_plen(PLEN_W'($urandom_range(256, 1022)));
    run_random(300, 900);

    write_plen(10'd1023);
    run_random(350, 1000);

    idle_on = 1'b0;
    run_random(150, 400);
    drain();

    shadow.close();
    if (shadow.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/nbce_pkg.sv
design/nbce_if.sv
design/nbce_dmem.sv
design/nbce_alu.sv
design/nine_bit_cpu_execute_step.sv
verif/nbce_tb_pkg.sv
verif/tb.sv
